FILE: rtl/fwqi_pkg.sv
// ============================================================================
// fwqi_pkg
// Shared types, constants and shape tables for the fuzzy water quality index.
// ============================================================================
package fwqi_pkg;

	// Q16 fixed point: 1.0 is 65536, memberships need 17 bits.
	localparam int MU_W = 17;
	localparam int X_W  = 17;
	localparam logic [MU_W-1:0] ONE_Q16    = 17'd65536;
	localparam logic [MU_W-1:0] SKIP_BELOW = 17'd66;
	localparam int EMPTY_BELOW = 7;

	// Index limits in hundredths.
	localparam logic [13:0] IDX_EMPTY = 14'd5000;
	localparam logic [13:0] IDX_MAX   = 14'd10000;

	// Input saturation limits.
	localparam logic [10:0] PH_MAX  = 11'd1400;
	localparam logic [14:0] NTU_MAX = 15'd30000;
	localparam logic signed [11:0] TEMP_MIN = -12'sd400;
	localparam logic signed [11:0] TEMP_MAX = 12'sd1250;

	// Input membership sets: three pH, three solids, two turbidity, three delta-T.
	localparam int NUM_MEMB = 11;
	localparam logic [3:0] MEMB_LAST = 4'd10;
	localparam logic [3:0] MEMB_TDS0 = 4'd3;
	localparam logic [3:0] MEMB_TU0  = 4'd6;
	localparam logic [3:0] MEMB_TP0  = 4'd8;

	// A slope division has a 14-bit distance over 16 fraction bits.
	localparam int MEMB_DIV_BITS = 30;

	// Register index within the configuration map.
	localparam logic REG_UNFIT = 1'b0;
	localparam logic REG_TREAT = 1'b1;

	// Output categories.
	localparam logic [1:0] CAT_UNFIT = 2'd0;
	localparam logic [1:0] CAT_TREAT = 2'd1;
	localparam logic [1:0] CAT_FIT   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEMB,
		ST_MDIV,
		ST_RULES,
		ST_CENT,
		ST_PREP_DEN,
		ST_PREP_NUM,
		ST_DSTART,
		ST_FDIV,
		ST_FIN
	} state_t;

	// Trapezoid corners a, b, c, d.
	typedef struct packed {
		logic signed [X_W-1:0] a;
		logic signed [X_W-1:0] b;
		logic signed [X_W-1:0] c;
		logic signed [X_W-1:0] d;
	} shape_t;

	function automatic shape_t shape_of(input logic [3:0] j);
		shape_t s;
		case (j)
			4'd0:    s = '{17'sd0,     17'sd0,     17'sd600,   17'sd700};
			4'd1:    s = '{17'sd650,   17'sd700,   17'sd700,   17'sd850};
			4'd2:    s = '{17'sd700,   17'sd900,   17'sd1400,  17'sd1400};
			4'd3:    s = '{17'sd0,     17'sd0,     17'sd300,   17'sd500};
			4'd4:    s = '{17'sd300,   17'sd600,   17'sd600,   17'sd1000};
			4'd5:    s = '{17'sd600,   17'sd1000,  17'sd1000,  17'sd1000};
			4'd6:    s = '{17'sd0,     17'sd0,     17'sd10,    17'sd50};
			4'd7:    s = '{17'sd0,     17'sd10,    17'sd50,    17'sd10000};
			4'd8:    s = '{-17'sd1000, -17'sd1000, -17'sd50,   -17'sd30};
			4'd9:    s = '{-17'sd50,   -17'sd30,   17'sd30,    17'sd50};
			4'd10:   s = '{17'sd30,    17'sd50,    17'sd1000,  17'sd1000};
			default: s = '{17'sd0,     17'sd0,     17'sd0,     17'sd0};
		endcase
		return s;
	endfunction

	// Output class of one rule.
	function automatic logic [1:0] rule_class(input logic [1:0] ph, input logic [1:0] tds,
		input logic tu, input logic [1:0] tp);
		logic [1:0] k;
		if (ph != 2'd1 || tu != 1'b0 || tds == 2'd2) begin
			k = CAT_UNFIT;
		end else if (tds == 2'd0 && tp == 2'd1) begin
			k = CAT_FIT;
		end else begin
			k = CAT_TREAT;
		end
		return k;
	endfunction

endpackage

FILE: rtl/fwqi_div.sv
// ============================================================================
// fwqi_div
// Restoring divider, one quotient bit per cycle, for a left-aligned dividend.
// ============================================================================
module fwqi_div #(
	parameter int DIV_W = 64,
	parameter int DEN_W = 40,
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] count,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dd_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// One trial subtraction per cycle.
	assign trial = {rem_q, dd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == CNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			dd_q  <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dd_q  <= {dd_q[DIV_W-2:0], 1'b0};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/fuzzy_water_quality_index.sv
// ============================================================================
// fuzzy_water_quality_index
// Mamdani fuzzy inference with centroid defuzzification for water quality.
// ============================================================================
// The input stream takes one beat of sensor readings (pH, dissolved solids,
// turbidity, water and air temperature). The output stream gives one beat per
// input: the quality index in hundredths and a three-way category.
// Two threshold registers sit behind an APB-style port at byte addresses 0
// and 4; write them only while the block is idle.
// The time from the accepted input beat to the output beat grows with S
// (at most 7), the number of input memberships that fall on a slope. At the
// default of 100 points DIV_W is 42. A reading that fires no rule skips the
// final quotient. The shared bit-serial divider sets most of the time: a
// sloped membership takes a divider run while a flat one is stored directly,
// the rule sweep takes one rule per cycle over all 54 rules, the centroid
// sum one sample per cycle, and the final quotient a DIV_W-bit divider run.
// s_tready is high only in the idle state, so one item is in work at a time.
// The result lands in an output register; a new item is taken while it waits.
// If the receiver still stalls the previous result when the next one is done,
// the block holds the new result internally until the register frees up.
// Reset clears the control state, returns the thresholds to 4000 and 6000 and
// leaves the output stream empty.
// ============================================================================
module fuzzy_water_quality_index #(
	parameter int POINTS = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream. tdata: ph_value[10:0], dissolved_solids[22:11],
	// turbidity[37:23], water_temp[49:38], air_temp[61:50], zero pad.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// Output stream. tdata: quality_index[13:0], category[15:14].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import fwqi_pkg::*;

	localparam longint P     = longint'(POINTS);
	localparam int     SN_W  = $clog2(P * (P + 1) / 2 * 65536 + 1);
	localparam int     SD_W  = $clog2((P + 1) * 65536 + 1);
	localparam int     DEN_W = $clog2(P * (P + 1) * 65536 + 1);
	localparam longint NUMV  = 10000 * P * (P + 1) / 2 * 65536 + P * (P + 1) * 65536 / 2;
	localparam int     NUM_W = $clog2(NUMV + 1);
	localparam int     DIV_W = (NUM_W > MEMB_DIV_BITS) ? NUM_W : MEMB_DIV_BITS;
	localparam int     CNT_W = $clog2(DIV_W + 1);
	localparam int     I_W   = $clog2(P + 1);
	localparam int     XS_W  = $clog2(100 * P + 101);
	localparam int     R_W   = $clog2(P);
	localparam int     F_W   = 20;
	localparam int     STEP_Q = 327680 / POINTS;
	localparam int     STEP_R = 327680 % POINTS;

	localparam logic [XS_W-1:0] X30 = XS_W'(30 * POINTS);
	localparam logic [XS_W-1:0] X50 = XS_W'(50 * POINTS);
	localparam logic [XS_W-1:0] X70 = XS_W'(70 * POINTS);

	state_t state_q, state_d;

	// Configuration registers.
	logic [13:0] unfit_q, treat_q;

	// Captured readings, with pH, turbidity and temperatures saturated.
	logic [10:0]        ph_q;
	logic [11:0]        tds_q;
	logic [14:0]        ntu_q;
	logic signed [11:0] dt_q;

	// Memberships and rule strengths.
	logic [3:0]      j_q;
	logic [MU_W-1:0] mph_q [3];
	logic [MU_W-1:0] mtds_q [3];
	logic [MU_W-1:0] mtu_q [2];
	logic [MU_W-1:0] mtp_q [3];
	logic [MU_W-1:0] str_q [3];

	// Rule sweep counters.
	logic [1:0] ra_q, rb_q, rd_q;
	logic       rc_q;

	// Centroid sample walk.
	logic [I_W-1:0]   i_q;
	logic [XS_W-1:0]  x_q;
	logic [F_W-1:0]   f_q;
	logic [R_W-1:0]   rem_q;
	logic [SN_W-1:0]  sum_num_q;
	logic [SD_W-1:0]  sum_den_q;
	logic [DEN_W-1:0] den_q;
	logic [DIV_W-1:0] num_q;
	logic [13:0]      idx_q;

	// Output register.
	logic        m_valid_q;
	logic [15:0] m_data_q;

	// Divider hookup.
	logic             div_start;
	logic [CNT_W-1:0] div_count;
	logic [DIV_W-1:0] div_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	// ---------------------------------------------------------------- input
	logic [10:0]        in_ph;
	logic [11:0]        in_tds;
	logic [14:0]        in_ntu;
	logic signed [11:0] in_tw, in_ta, tw_c, ta_c;
	logic               in_acc;

	assign in_ph  = s_tdata[10:0];
	assign in_tds = s_tdata[22:11];
	assign in_ntu = s_tdata[37:23];
	assign in_tw  = s_tdata[49:38];
	assign in_ta  = s_tdata[61:50];
	assign tw_c   = (in_tw < TEMP_MIN) ? TEMP_MIN : ((in_tw > TEMP_MAX) ? TEMP_MAX : in_tw);
	assign ta_c   = (in_ta < TEMP_MIN) ? TEMP_MIN : ((in_ta > TEMP_MAX) ? TEMP_MAX : in_ta);
	assign s_tready = state_q == ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;

	// ------------------------------------------------- membership evaluation
	shape_t                sh;
	logic signed [X_W-1:0] xv;
	logic                  is_slope;
	logic [MU_W-1:0]       direct_mu;
	logic signed [X_W-1:0] dist_s, span_s;
	logic [MU_W-1:0]       store_mu;
	logic                  store_en;

	always_comb begin
		sh = shape_of(j_q);
		if (j_q < MEMB_TDS0) begin
			xv = X_W'(signed'({1'b0, ph_q}));
		end else if (j_q < MEMB_TU0) begin
			xv = X_W'(signed'({1'b0, tds_q}));
		end else if (j_q < MEMB_TP0) begin
			xv = X_W'(signed'({1'b0, ntu_q}));
		end else begin
			xv = X_W'(dt_q);
		end
		is_slope  = 1'b0;
		direct_mu = '0;
		dist_s    = xv - sh.a;
		span_s    = sh.b - sh.a;
		if (xv >= sh.b && xv <= sh.c) begin
			direct_mu = ONE_Q16;
		end else if (xv < sh.b) begin
			if (sh.a == sh.b) begin
				direct_mu = ONE_Q16;
			end else if (xv > sh.a) begin
				is_slope = 1'b1;
			end
		end else begin
			dist_s = sh.d - xv;
			span_s = sh.d - sh.c;
			if (sh.c == sh.d) begin
				direct_mu = ONE_Q16;
			end else if (xv < sh.d) begin
				is_slope = 1'b1;
			end
		end
		store_en = (state_q == ST_MEMB && !is_slope) || (state_q == ST_MDIV && div_done);
		store_mu = (state_q == ST_MDIV) ? div_quot[MU_W-1:0] : direct_mu;
	end

	// ------------------------------------------------------------ rule sweep
	logic [MU_W-1:0] r_min01, r_min23, r_s;
	logic [1:0]      r_k;
	logic            r_skip, r_last;

	always_comb begin
		r_min01 = (mph_q[ra_q] < mtds_q[rb_q]) ? mph_q[ra_q] : mtds_q[rb_q];
		r_min23 = (mtu_q[rc_q] < mtp_q[rd_q]) ? mtu_q[rc_q] : mtp_q[rd_q];
		r_s     = (r_min01 < r_min23) ? r_min01 : r_min23;
		r_k     = rule_class(ra_q, rb_q, rc_q, rd_q);
		r_skip  = mph_q[ra_q] < SKIP_BELOW || mtds_q[rb_q] < SKIP_BELOW ||
			mtu_q[rc_q] < SKIP_BELOW || mtp_q[rd_q] < SKIP_BELOW;
		r_last  = ra_q == 2'd2 && rb_q == 2'd2 && rc_q && rd_q == 2'd2;
	end

	// ------------------------------------------------------- centroid sample
	logic [F_W-1:0]  f_ceil;
	logic [F_W-1:0]  m0w, m1w, m2w;
	logic [MU_W-1:0] m0, m1, m2, mu;
	logic [R_W:0]    rem_next;

	always_comb begin
		f_ceil = f_q + F_W'(rem_q != '0);
		if (x_q <= X30) begin
			m0w = F_W'(ONE_Q16);
		end else if (x_q < X50) begin
			m0w = F_W'(163840) - f_ceil;
		end else begin
			m0w = '0;
		end
		if (x_q <= X30) begin
			m1w = '0;
		end else if (x_q < X50) begin
			m1w = f_q - F_W'(98304);
		end else if (x_q == X50) begin
			m1w = F_W'(ONE_Q16);
		end else if (x_q < X70) begin
			m1w = F_W'(229376) - f_ceil;
		end else begin
			m1w = '0;
		end
		if (x_q <= X50) begin
			m2w = '0;
		end else if (x_q < X70) begin
			m2w = f_q - F_W'(163840);
		end else begin
			m2w = F_W'(ONE_Q16);
		end
		m0 = (m0w[MU_W-1:0] < str_q[0]) ? m0w[MU_W-1:0] : str_q[0];
		m1 = (m1w[MU_W-1:0] < str_q[1]) ? m1w[MU_W-1:0] : str_q[1];
		m2 = (m2w[MU_W-1:0] < str_q[2]) ? m2w[MU_W-1:0] : str_q[2];
		mu = m0;
		if (m1 > mu) begin
			mu = m1;
		end
		if (m2 > mu) begin
			mu = m2;
		end
		rem_next = {1'b0, rem_q} + (R_W + 1)'(STEP_R);
	end

	// ------------------------------------------------------ final index pick
	logic [13:0] q_idx;
	logic [1:0]  cat;
	logic        out_free;

	assign q_idx    = (div_quot > DIV_W'(IDX_MAX)) ? IDX_MAX : div_quot[13:0];
	assign cat      = (idx_q < unfit_q) ? CAT_UNFIT : ((idx_q < treat_q) ? CAT_TREAT : CAT_FIT);
	assign out_free = !m_valid_q || m_tready;

	// -------------------------------------------------------- state machine
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_count    = CNT_W'(MEMB_DIV_BITS);
		div_dividend = DIV_W'({dist_s[13:0], 16'h0000}) << (DIV_W - MEMB_DIV_BITS);
		div_divisor  = DEN_W'(span_s[13:0]);
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_MEMB;
				end
			end
			ST_MEMB: begin
				if (is_slope) begin
					div_start = 1'b1;
					state_d   = ST_MDIV;
				end else if (j_q == MEMB_LAST) begin
					state_d = ST_RULES;
				end
			end
			ST_MDIV: begin
				if (div_done) begin
					state_d = (j_q == MEMB_LAST) ? ST_RULES : ST_MEMB;
				end
			end
			ST_RULES: begin
				if (r_last) begin
					state_d = ST_CENT;
				end
			end
			ST_CENT: begin
				if (i_q == I_W'(POINTS)) begin
					state_d = ST_PREP_DEN;
				end
			end
			ST_PREP_DEN: begin
				state_d = ST_PREP_NUM;
			end
			ST_PREP_NUM: begin
				state_d = (sum_den_q < SD_W'(EMPTY_BELOW)) ? ST_FIN : ST_DSTART;
			end
			ST_DSTART: begin
				div_start    = 1'b1;
				div_count    = CNT_W'(DIV_W);
				div_dividend = num_q;
				div_divisor  = den_q;
				state_d      = ST_FDIV;
			end
			ST_FDIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ----------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		// Capture readings, saturating pH, turbidity and temperatures.
		if (in_acc) begin
			ph_q  <= (in_ph > PH_MAX) ? PH_MAX : in_ph;
			tds_q <= in_tds;
			ntu_q <= (in_ntu > NTU_MAX) ? NTU_MAX : in_ntu;
			dt_q  <= tw_c - ta_c;
			j_q   <= '0;
		end
		// Store one membership.
		if (store_en) begin
			if (j_q < MEMB_TDS0) begin
				mph_q[j_q[1:0]] <= store_mu;
			end else if (j_q < MEMB_TU0) begin
				mtds_q[2'(j_q - MEMB_TDS0)] <= store_mu;
			end else if (j_q < MEMB_TP0) begin
				mtu_q[1'(j_q - MEMB_TU0)] <= store_mu;
			end else begin
				mtp_q[2'(j_q - MEMB_TP0)] <= store_mu;
			end
			j_q <= j_q + 4'd1;
			if (j_q == MEMB_LAST) begin
				ra_q  <= '0;
				rb_q  <= '0;
				rc_q  <= 1'b0;
				rd_q  <= '0;
				str_q <= '{default: '0};
			end
		end
		// Sweep the rules, one per cycle, in nested order.
		if (state_q == ST_RULES) begin
			if (!r_skip && r_s > str_q[r_k]) begin
				str_q[r_k] <= r_s;
			end
			if (rd_q != 2'd2) begin
				rd_q <= rd_q + 2'd1;
			end else begin
				rd_q <= '0;
				rc_q <= !rc_q;
				if (rc_q) begin
					if (rb_q != 2'd2) begin
						rb_q <= rb_q + 2'd1;
					end else begin
						rb_q <= '0;
						ra_q <= ra_q + 2'd1;
					end
				end
			end
			if (r_last) begin
				i_q       <= '0;
				x_q       <= '0;
				f_q       <= '0;
				rem_q     <= '0;
				sum_num_q <= '0;
				sum_den_q <= '0;
			end
		end
		// Accumulate one centroid sample.
		if (state_q == ST_CENT) begin
			sum_num_q <= sum_num_q + SN_W'(i_q) * SN_W'(mu);
			sum_den_q <= sum_den_q + SD_W'(mu);
			i_q       <= i_q + I_W'(1);
			x_q       <= x_q + XS_W'(100);
			if (rem_next >= (R_W + 1)'(POINTS)) begin
				rem_q <= R_W'(rem_next - (R_W + 1)'(POINTS));
				f_q   <= f_q + F_W'(STEP_Q + 1);
			end else begin
				rem_q <= rem_next[R_W-1:0];
				f_q   <= f_q + F_W'(STEP_Q);
			end
		end
		// Build the centroid fraction with rounding.
		if (state_q == ST_PREP_DEN) begin
			den_q <= DEN_W'(sum_den_q) * DEN_W'(POINTS);
		end
		if (state_q == ST_PREP_NUM) begin
			num_q <= DIV_W'(sum_num_q) * DIV_W'(10000) + DIV_W'(den_q >> 1);
			idx_q <= IDX_EMPTY;
		end
		if (state_q == ST_FDIV && div_done) begin
			idx_q <= q_idx;
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {cat, idx_q};
		end
	end

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// -------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unfit_q <= 14'd4000;
			treat_q <= 14'd6000;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_UNFIT) begin
				unfit_q <= pwdata[13:0];
			end else begin
				treat_q <= pwdata[13:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TREAT) ? {18'd0, treat_q} : {18'd0, unfit_q};

	// -------------------------------------------------------- shared divider
	fwqi_div #(
		.DIV_W(DIV_W),
		.DEN_W(DEN_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.count    (div_count),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Water quality index testbench
// Drives sensor readings into the fuzzy index block, predicts each index and
// category in fixed point, and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fwqi_pkg::*;

	localparam int NPTS = 100;
	localparam logic [2:0] ADDR_UNFIT = 3'd0;
	localparam logic [2:0] ADDR_TREAT = 3'd4;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 700;

	typedef struct packed {
		logic [13:0] idx;
		logic [1:0]  cat;
	} grade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fuzzy_water_quality_index #(.POINTS(NPTS)) i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the thresholds.
	int unsigned unfit_lim = 4000, treat_lim = 6000;
	grade_t grades_due[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_cycles = 0;
	longint cycles = 0;

	// Trapezoid membership in Q16 with full shoulders.
	function automatic longint memb(longint x, longint a, longint b, longint c, longint d);
		if (x >= b && x <= c) return 65536;
		if (x < b) begin
			if (a == b) return 65536;
			if (x <= a) return 0;
			return (x - a) * 65536 / (b - a);
		end
		if (c == d) return 65536;
		if (x >= d) return 0;
		return (d - x) * 65536 / (d - c);
	endfunction

	function automatic grade_t grade_reading(logic [63:0] w);
		longint ph, tds, ntu, tw, ta, dt, s, x, m0, m1, m2, mu, num, den, q;
		longint mph[3], mtd[3], mtu[2], mtp[3], str[3];
		logic [1:0] k;
		grade_t g;
		ph = longint'(w[10:0]);
		if (ph > 1400) ph = 1400;
		tds = longint'(w[22:11]);
		ntu = longint'(w[37:23]);
		if (ntu > 30000) ntu = 30000;
		tw = longint'($signed(w[49:38]));
		ta = longint'($signed(w[61:50]));
		tw = tw < -400 ? -400 : (tw > 1250 ? 1250 : tw);
		ta = ta < -400 ? -400 : (ta > 1250 ? 1250 : ta);
		dt = tw - ta;
		mph[0] = memb(ph, 0, 0, 600, 700);
		mph[1] = memb(ph, 650, 700, 700, 850);
		mph[2] = memb(ph, 700, 900, 1400, 1400);
		mtd[0] = memb(tds, 0, 0, 300, 500);
		mtd[1] = memb(tds, 300, 600, 600, 1000);
		mtd[2] = memb(tds, 600, 1000, 1000, 1000);
		mtu[0] = memb(ntu, 0, 0, 10, 50);
		mtu[1] = memb(ntu, 0, 10, 50, 10000);
		mtp[0] = memb(dt, -1000, -1000, -50, -30);
		mtp[1] = memb(dt, -50, -30, 30, 50);
		mtp[2] = memb(dt, 30, 50, 1000, 1000);
		str = '{0, 0, 0};
		// Min/max sweep over the rule table, weak memberships skipped.
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				for (int c = 0; c < 2; c++)
					for (int d = 0; d < 3; d++) begin
						if (mph[a] < 66 || mtd[b] < 66 || mtu[c] < 66 || mtp[d] < 66)
							continue;
						s = mph[a];
						if (mtd[b] < s) s = mtd[b];
						if (mtu[c] < s) s = mtu[c];
						if (mtp[d] < s) s = mtp[d];
						if (a != 1 || c != 0 || b == 2) k = CAT_UNFIT;
						else if (b == 0 && d == 1) k = CAT_FIT;
						else k = CAT_TREAT;
						if (s > str[k]) str[k] = s;
					end
		// Centroid over the sampled output universe.
		num = 0;
		den = 0;
		for (int i = 0; i <= NPTS; i++) begin
			x = 100 * i;
			m0 = memb(x, 0, 0, 30 * NPTS, 50 * NPTS);
			if (str[0] < m0) m0 = str[0];
			m1 = memb(x, 30 * NPTS, 50 * NPTS, 50 * NPTS, 70 * NPTS);
			if (str[1] < m1) m1 = str[1];
			m2 = memb(x, 50 * NPTS, 70 * NPTS, 100 * NPTS, 100 * NPTS);
			if (str[2] < m2) m2 = str[2];
			mu = m0;
			if (m1 > mu) mu = m1;
			if (m2 > mu) mu = m2;
			num += i * mu;
			den += mu;
		end
		if (den < 7) q = 5000;
		else begin
			q = (10000 * num + NPTS * den / 2) / (NPTS * den);
			if (q > 10000) q = 10000;
		end
		g.idx = q[13:0];
		if (q < unfit_lim) g.cat = CAT_UNFIT;
		else if (q < treat_lim) g.cat = CAT_TREAT;
		else g.cat = CAT_FIT;
		return g;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Output side: random stall, long hold when requested, check each beat.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			if (grades_due.size() == 0) report_mismatch("unexpected beat", int'(m_tdata), 0);
			else begin
				grade_t g;
				g = grades_due.pop_front();
				if (m_tdata[13:0] !== g.idx)
					report_mismatch("index", int'(m_tdata[13:0]), int'(g.idx));
				if (m_tdata[15:14] !== g.cat)
					report_mismatch("category", int'(m_tdata[15:14]), int'(g.cat));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] addr, int unsigned val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_UNFIT) unfit_lim = val & 14'h3fff;
		else treat_lim = val & 14'h3fff;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_reading(int ph, int tds, int ntu, int tw, int ta);
		logic [63:0] w;
		w = '0;
		w[10:0] = 11'(ph);
		w[22:11] = 12'(tds);
		w[37:23] = 15'(ntu);
		w[49:38] = 12'(tw);
		w[61:50] = 12'(ta);
		// Always move on by at least one falling edge, then idle at random.
		do @(negedge clk); while ($urandom_range(99) < send_idle);
		s_tdata <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		grades_due.push_back(grade_reading(w));
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (grades_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mostly in-range readings, some raw full-width noise.
	task automatic send_random();
		if ($urandom_range(9) < 2)
			send_reading($urandom_range(2047), $urandom_range(4095), $urandom_range(32767),
				$urandom_range(4095), $urandom_range(4095));
		else if ($urandom_range(1))
			send_reading($urandom_range(600, 850), $urandom_range(0, 700), $urandom_range(0, 80),
				$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
		else
			send_reading($urandom_range(1400), $urandom_range(1100), $urandom_range(12000),
				$urandom_range(1650) - 400, $urandom_range(1650) - 400);
	endtask

	task automatic test_directed();
		send_reading(0, 0, 0, -400, -400);
		send_reading(1400, 4095, 30000, 1250, 1250);
		send_reading(2047, 4095, 32767, 2047, -2048);
		send_reading(700, 100, 5, 200, 200);
		send_reading(700, 400, 5, 200, 200);
		send_reading(700, 800, 5, 200, 200);
		send_reading(700, 100, 30, 240, 200);
		send_reading(700, 100, 5, 160, 200);
		send_reading(660, 310, 5, 240, 200);
		send_reading(800, 100, 100, 200, 200);
		send_reading(700, 100, 5, 1250, -400);
		send_reading(700, 100, 5, -400, 1250);
		send_reading(650, 300, 10, 230, 200);
		send_reading(850, 1000, 50, 250, 200);
		send_reading(700, 100, 9999, 200, 200);
		send_reading(700, 0, 0, 0, 0);
		send_reading(1024, 2048, 16384, -2048, 1024);
		drain();
	endtask

	task automatic test_thresholds();
		write_reg(ADDR_UNFIT, 0);
		write_reg(ADDR_TREAT, 16383);
		repeat (40) send_random();
		drain();
		write_reg(ADDR_UNFIT, 10000);
		write_reg(ADDR_TREAT, 10000);
		repeat (40) send_random();
		drain();
		write_reg(ADDR_UNFIT, 3000);
		write_reg(ADDR_TREAT, 5000);
		repeat (40) send_random();
		drain();
		write_reg(ADDR_UNFIT, 4000);
		write_reg(ADDR_TREAT, 6000);
	endtask

	task automatic test_backpressure();
		hold_cycles = 3000;
		repeat (6) send_random();
		drain();
	endtask

	task automatic test_random(int n);
		repeat (n) send_random();
		drain();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_thresholds();
		test_backpressure();
		send_idle = 24;
		recv_idle = 50;
		test_random(330);
		send_idle = 50;
		recv_idle = 24;
		test_random(330);
		send_idle = 0;
		recv_idle = 0;
		test_random(330);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
